// ===== src/ccc_pkg.sv =====
package ccc_pkg;

	localparam int DEF_FRAC_BITS = 15;

	localparam int IN_W   = 16;
	localparam int OUT_W  = 16;
	localparam int OFS_W  = 16;
	localparam int KMAX_W = 15;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 1;

	localparam logic [IDX_W-1:0] REG_BLACK_OFFSET = 1'b0;
	localparam logic [IDX_W-1:0] REG_BLACK_MAX    = 1'b1;

	localparam logic CMD_RGB2CMYK = 1'b0;
	localparam logic CMD_CMYK2RGB = 1'b1;

	localparam logic [OFS_W-1:0]  RST_BLACK_OFFSET = 16'd6554;
	localparam logic [KMAX_W-1:0] RST_BLACK_MAX    = 15'd26214;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef struct packed {
		logic valid;
		logic cmd;
	} ctrl_t;

endpackage

// ===== src/rgb_cmyk_color_converter.sv =====
// throughput: one pixel per cycle, set by a fully pipelined divider of FRAC_BITS + 1
//   compare-subtract stages in each of the three color lanes
// the receiver cannot stall: each result shows for one cycle with done high
// reset: arst_n low clears the pipeline valid bits and loads the default
//   black_offset (0.2) and black_max (0.8)
module rgb_cmyk_color_converter
	import ccc_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// command side
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [IN_W-1:0]   in_a,
	input  logic [IN_W-1:0]   in_b,
	input  logic [IN_W-1:0]   in_c,
	input  logic [IN_W-1:0]   in_d,
	// result side
	output logic              done,
	output logic [OUT_W-1:0]  out_a,
	output logic [OUT_W-1:0]  out_b,
	output logic [OUT_W-1:0]  out_c,
	output logic [OUT_W-1:0]  out_d
);

	localparam int LAT = FRAC_BITS + 4;

	// configuration registers
	logic [OFS_W-1:0]  black_offset_q;
	logic [KMAX_W-1:0] black_max_q;

	// front end outputs, aligned at stage 2
	ctrl_t              ctrl_in;
	ctrl_t              ctrl_s2;
	logic [FRAC_BITS:0] op_s2 [3];
	logic [FRAC_BITS:0] k_s2;

	// lane results
	logic [FRAC_BITS:0] quo [3];
	logic [FRAC_BITS:0] rev [3];

	// items never wait: a new transaction enters every cycle
	assign busy = 1'b0;

	assign ctrl_in.valid = start && !busy;
	assign ctrl_in.cmd   = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_offset_q <= RST_BLACK_OFFSET;
			black_max_q    <= RST_BLACK_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLACK_OFFSET: black_offset_q <= cfg_data;
				REG_BLACK_MAX:    black_max_q    <= cfg_data[KMAX_W-1:0];
				default:          ;
			endcase
		end
	end

	// input saturation, cmy complement and black generation
	ccc_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl_in      (ctrl_in),
		.in_a         (in_a),
		.in_b         (in_b),
		.in_c         (in_c),
		.in_d         (in_d),
		.black_offset (black_offset_q),
		.black_max    (black_max_q),
		.ctrl_s2      (ctrl_s2),
		.op_s2        (op_s2),
		.k_s2         (k_s2)
	);

	// one lane per color channel: under color removal divide or reverse scale
	for (genvar i = 0; i < 3; i++) begin : g_lane
		ccc_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk (clk),
			.op  (op_s2[i]),
			.k   (k_s2),
			.quo (quo[i]),
			.rev (rev[i])
		);
	end

	// direction select, output saturation and result register
	ccc_merge #(
		.FRAC_BITS(FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s2 (ctrl_s2),
		.k_s2    (k_s2),
		.quo     (quo),
		.rev     (rev),
		.done    (done),
		.out_a   (out_a),
		.out_b   (out_b),
		.out_c   (out_c),
		.out_d   (out_d)
	);

	// every result traces back to an accepted transaction, checked with $past of start
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching transaction");

	// black output is only nonzero for forward conversion
	a_black_fwd_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (out_d != '0)) |-> ($past(cmd, LAT) == CMD_RGB2CMYK))
		else $error("nonzero black on a cmyk to rgb result");

	// the done strobe is never held for a cycle without a transaction behind it
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done)) |-> ($past(start, LAT) && $past(start, LAT + 1)))
		else $error("done held without back to back transactions");

endmodule

// ===== src/ccc_front.sv =====
module ccc_front
	import ccc_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_t                ctrl_in,
	input  logic [IN_W-1:0]      in_a,
	input  logic [IN_W-1:0]      in_b,
	input  logic [IN_W-1:0]      in_c,
	input  logic [IN_W-1:0]      in_d,
	input  logic [OFS_W-1:0]     black_offset,
	input  logic [KMAX_W-1:0]    black_max,
	output ctrl_t                ctrl_s2,
	output logic [FRAC_BITS:0]   op_s2 [3],
	output logic [FRAC_BITS:0]   k_s2
);

	localparam int W   = FRAC_BITS + 1;
	localparam int CW  = (W > IN_W) ? W : IN_W;
	localparam int CW2 = (W > OFS_W) ? W : OFS_W;
	localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	function automatic logic [W-1:0] sat_one(input logic [IN_W-1:0] v);
		logic [CW-1:0] ve;
		logic [CW-1:0] one_e;
		ve    = CW'(v);
		one_e = CW'(ONE);
		return (ve > one_e) ? ONE : ve[W-1:0];
	endfunction

	ctrl_t        ctrl_s1;
	logic [W-1:0] op_s1 [3];
	logic [W-1:0] d_s1;

	logic [W-1:0]   sat_x [3];
	logic [W-1:0]   mn;
	logic [CW2-1:0] mn_e;
	logic [CW2-1:0] ofs_e;
	logic [CW2-1:0] kmax_e;
	logic [CW2-1:0] klim_e;
	logic [CW2-1:0] k_raw;
	logic [CW2-1:0] k_max;
	logic [CW2-1:0] k_fin;

	assign sat_x[0] = sat_one(in_a);
	assign sat_x[1] = sat_one(in_b);
	assign sat_x[2] = sat_one(in_c);

	// stage 1: saturate, complement to cmy for the forward direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			op_s1[i] <= (ctrl_in.cmd == CMD_CMYK2RGB) ? sat_x[i] : ONE - sat_x[i];
		end
		d_s1 <= sat_one(in_d);
	end

	// stage 2: black from min cmy, offset and clamps going forward; the black input in reverse
	always_comb begin
		mn     = (op_s1[0] < op_s1[1]) ? op_s1[0] : op_s1[1];
		mn     = (mn < op_s1[2]) ? mn : op_s1[2];
		mn_e   = CW2'(mn);
		ofs_e  = CW2'(black_offset);
		kmax_e = CW2'(black_max);
		klim_e = CW2'(ONE - 1'b1);
		k_raw  = (mn_e > ofs_e) ? mn_e - ofs_e : '0;
		k_max  = (k_raw > kmax_e) ? kmax_e : k_raw;
		k_fin  = (k_max > klim_e) ? klim_e : k_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		k_s2  <= (ctrl_s1.cmd == CMD_CMYK2RGB) ? d_s1 : k_fin[W-1:0];
	end

endmodule

// ===== src/ccc_lane.sv =====
module ccc_lane
	import ccc_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic [FRAC_BITS:0] op,
	input  logic [FRAC_BITS:0] k,
	output logic [FRAC_BITS:0] quo,
	output logic [FRAC_BITS:0] rev
);

	localparam int W     = FRAC_BITS + 1;
	localparam int DEPTH = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// divider stages, indexed by stage
	logic [W-1:0] rem_s [DEPTH];
	logic [W-1:0] quo_s [DEPTH];
	logic [W-1:0] div_s [DEPTH];
	logic [W-1:0] rev_s [DEPTH];

	logic [2*W-1:0] prod_s0;
	logic [W-1:0]   kadd_s0;

	logic [W-1:0] num;
	logic [W-1:0] dvs;
	logic         bit0;
	logic [W:0]   sum1;
	logic [W-1:0] sat1;

	assign num  = op - k;
	assign dvs  = ONE - k;
	assign bit0 = (num >= dvs);

	// first step yields the integer bit, product for the reverse path
	always_ff @(posedge clk) begin
		rem_s[0] <= bit0 ? num - dvs : num;
		quo_s[0] <= W'(bit0);
		div_s[0] <= dvs;
		prod_s0  <= (2*W)'(op) * (2*W)'(dvs);
		kadd_s0  <= k;
	end

	// reverse result: scale, add black, clamp, complement
	always_comb begin
		sum1 = prod_s0[2*W-1:FRAC_BITS] + (W+1)'(kadd_s0);
		sat1 = (sum1 > (W+1)'(ONE)) ? ONE : sum1[W-1:0];
	end

	always_ff @(posedge clk) begin
		rev_s[0] <= '0;
		rev_s[1] <= ONE - sat1;
	end

	for (genvar j = 1; j < DEPTH; j++) begin : g_step
		logic [W:0] r2;
		logic       qb;

		assign r2 = {rem_s[j-1], 1'b0};
		assign qb = (r2 >= (W+1)'(div_s[j-1]));

		always_ff @(posedge clk) begin
			rem_s[j] <= qb ? W'(r2 - (W+1)'(div_s[j-1])) : r2[W-1:0];
			quo_s[j] <= {quo_s[j-1][W-2:0], qb};
			div_s[j] <= div_s[j-1];
		end

		if (j >= 2) begin : g_rev
			always_ff @(posedge clk) begin
				rev_s[j] <= rev_s[j-1];
			end
		end
	end

	assign quo = quo_s[DEPTH-1];
	assign rev = (DEPTH > 1) ? rev_s[DEPTH-1] : rev_s[0];

endmodule

// ===== src/ccc_merge.sv =====
module ccc_merge
	import ccc_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctrl_s2,
	input  logic [FRAC_BITS:0] k_s2,
	input  logic [FRAC_BITS:0] quo [3],
	input  logic [FRAC_BITS:0] rev [3],
	output logic               done,
	output logic [OUT_W-1:0]   out_a,
	output logic [OUT_W-1:0]   out_b,
	output logic [OUT_W-1:0]   out_c,
	output logic [OUT_W-1:0]   out_d
);

	localparam int W     = FRAC_BITS + 1;
	localparam int DEPTH = FRAC_BITS + 1;
	localparam int OW    = (W > OUT_W) ? W : OUT_W;

	function automatic logic [OUT_W-1:0] sat_out(input logic [W-1:0] v);
		logic [OW-1:0] ve;
		ve = OW'(v);
		return (ve > OW'(OUT_MAX)) ? OUT_MAX : ve[OUT_W-1:0];
	endfunction

	ctrl_t        ctrl_dly_q [DEPTH];
	logic [W-1:0] k_dly_q    [DEPTH];

	logic             done_q;
	logic [OUT_W-1:0] res_q [4];
	logic [W-1:0]     pick  [3];
	logic             fwd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DEPTH; j++) begin
				ctrl_dly_q[j] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			ctrl_dly_q[0] <= ctrl_s2;
			for (int j = 1; j < DEPTH; j++) begin
				ctrl_dly_q[j] <= ctrl_dly_q[j-1];
			end
			done_q <= ctrl_dly_q[DEPTH-1].valid;
		end
	end

	assign fwd = (ctrl_dly_q[DEPTH-1].cmd == CMD_RGB2CMYK);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pick[i] = fwd ? quo[i] : rev[i];
		end
	end

	always_ff @(posedge clk) begin
		k_dly_q[0] <= k_s2;
		for (int j = 1; j < DEPTH; j++) begin
			k_dly_q[j] <= k_dly_q[j-1];
		end
		for (int i = 0; i < 3; i++) begin
			res_q[i] <= sat_out(pick[i]);
		end
		res_q[3] <= fwd ? sat_out(k_dly_q[DEPTH-1]) : '0;
	end

	assign done  = done_q;
	assign out_a = res_q[0];
	assign out_b = res_q[1];
	assign out_c = res_q[2];
	assign out_d = res_q[3];

endmodule

// ===== test/tb.sv =====
module tb;
	import ccc_pkg::*;

	localparam int FRAC_BITS  = DEF_FRAC_BITS;
	// pipeline depth of the converter, from start to done
	localparam int LATENCY    = FRAC_BITS + 4;
	localparam int MAX_CYCLES = 200000;

	// one pixel as presented on the command side, channel 0..3 = in_a..in_d
	typedef struct {
		logic                   cmd;
		logic [3:0][IN_W-1:0]   chan;
	} pixel_in_t;

	// one converted pixel, channel 0..3 = out_a..out_d
	typedef logic [3:0][OUT_W-1:0] pixel_out_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              start = 1'b0;
	logic              busy;
	logic              cmd = CMD_RGB2CMYK;
	logic [IN_W-1:0]   in_a = '0;
	logic [IN_W-1:0]   in_b = '0;
	logic [IN_W-1:0]   in_c = '0;
	logic [IN_W-1:0]   in_d = '0;
	logic              done;
	logic [OUT_W-1:0]  out_a;
	logic [OUT_W-1:0]  out_b;
	logic [OUT_W-1:0]  out_c;
	logic [OUT_W-1:0]  out_d;

	// pixels waiting to be sent, and colors the converter still owes us
	pixel_in_t   pending_pixels[$];
	pixel_out_t  predicted_colors[$];

	// local copy of the under-color removal registers
	logic [OFS_W-1:0]   cur_offset = RST_BLACK_OFFSET;
	logic [KMAX_W-1:0]  cur_kmax   = RST_BLACK_MAX;

	// chance in percent that the sender sits out a cycle
	int unsigned gap_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	string chan_name[4] = '{"out_a", "out_b", "out_c", "out_d"};

	rgb_cmyk_color_converter #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.in_a(in_a),
		.in_b(in_b),
		.in_c(in_c),
		.in_d(in_d),
		.done(done),
		.out_a(out_a),
		.out_b(out_b),
		.out_c(out_c),
		.out_d(out_d)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// saturate a channel to 1.0
	function automatic logic [63:0] clip_unit(logic [63:0] v);
		logic [63:0] unit;
		unit = 64'd1 << FRAC_BITS;
		return (v > unit) ? unit : v;
	endfunction

	// saturate to the output word
	function automatic logic [63:0] clip_word(logic [63:0] v);
		return (v > 64'(OUT_MAX)) ? 64'(OUT_MAX) : v;
	endfunction

	// expected color for one pixel under the current black settings
	function automatic pixel_out_t convert_pixel(pixel_in_t px);
		logic [63:0] unit;
		logic [63:0] ch[3];
		logic [63:0] blk;
		logic [63:0] lowest;
		logic [63:0] rest;
		logic [63:0] mixed;
		pixel_out_t  res;
		unit = 64'd1 << FRAC_BITS;
		blk  = clip_unit(64'(px.chan[3]));
		for (int i = 0; i < 3; i++)
			ch[i] = clip_unit(64'(px.chan[i]));
		if (px.cmd == CMD_RGB2CMYK) begin
			// complement to cmy, black from the darkest ink less the offset
			for (int i = 0; i < 3; i++)
				ch[i] = unit - ch[i];
			lowest = ch[0];
			if (ch[1] < lowest)
				lowest = ch[1];
			if (ch[2] < lowest)
				lowest = ch[2];
			blk = (lowest > 64'(cur_offset)) ? lowest - 64'(cur_offset) : 64'd0;
			if (blk > 64'(cur_kmax))
				blk = 64'(cur_kmax);
			// keep the divisor above zero
			if (blk > unit - 1)
				blk = unit - 1;
			rest = unit - blk;
			for (int i = 0; i < 3; i++)
				res[i] = OUT_W'(clip_word(((ch[i] - blk) << FRAC_BITS) / rest));
			res[3] = OUT_W'(clip_word(blk));
		end else begin
			// add black back into each ink, then complement to rgb
			rest = unit - blk;
			for (int i = 0; i < 3; i++) begin
				mixed  = clip_unit(((ch[i] * rest) >> FRAC_BITS) + blk);
				res[i] = OUT_W'(clip_word(unit - mixed));
			end
			res[3] = '0;
		end
		return res;
	endfunction

	// mostly legal channel values, with the ends and out-of-range words mixed in
	function automatic logic [IN_W-1:0] rand_chan();
		int unsigned pick;
		logic [63:0] unit;
		unit = 64'd1 << FRAC_BITS;
		pick = $urandom_range(15);
		if (pick == 0)
			return IN_W'($urandom);
		else if (pick == 1)
			return '0;
		else if (pick == 2)
			return IN_W'(unit);
		return IN_W'($urandom_range(int'(unit)));
	endfunction

	task automatic add_pixel(input logic c, input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
			input logic [IN_W-1:0] y, input logic [IN_W-1:0] k);
		pixel_in_t px;
		px.cmd  = c;
		px.chan = {k, y, b, a};
		pending_pixels.push_back(px);
	endtask

	task automatic add_random_pixels(input int unsigned count, input int unsigned pct);
		gap_pct = pct;
		repeat (count)
			add_pixel(1'($urandom_range(1)), rand_chan(), rand_chan(), rand_chan(), rand_chan());
	endtask

	// only called with nothing in flight, so the local copy can follow at once
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BLACK_OFFSET)
			cur_offset = OFS_W'(val);
		else
			cur_kmax = KMAX_W'(val);
	endtask

	// sender holds off until every converted pixel is back
	task automatic drain();
		while (pending_pixels.size() != 0 || predicted_colors.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// driver: one transaction per start with busy low
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predicted_colors.push_back(convert_pixel(pending_pixels[0]));
				void'(pending_pixels.pop_front());
			end
			if (start && busy) begin
				// hold the offered pixel until it is taken
			end else if (pending_pixels.size() != 0 && $urandom_range(99) >= gap_pct) begin
				start <= 1'b1;
				cmd   <= pending_pixels[0].cmd;
				in_a  <= pending_pixels[0].chan[0];
				in_b  <= pending_pixels[0].chan[1];
				in_c  <= pending_pixels[0].chan[2];
				in_d  <= pending_pixels[0].chan[3];
			end else begin
				// idle cycle, scramble the payload so stale data is never trusted
				start <= 1'b0;
				cmd   <= 1'($urandom);
				in_a  <= IN_W'($urandom);
				in_b  <= IN_W'($urandom);
				in_c  <= IN_W'($urandom);
				in_d  <= IN_W'($urandom);
			end
		end
	end

	// monitor: every done pulse is one transaction on the result side
	always @(posedge clk) begin
		pixel_out_t got;
		pixel_out_t want;
		if (arst_n && done) begin
			got = {out_d, out_c, out_b, out_a};
			if (predicted_colors.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, nothing pending, got %h %h %h %h",
					$time, out_a, out_b, out_c, out_d);
			end else begin
				want = predicted_colors.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i] !== want[i]) begin
						mismatches++;
						$display("%0t: %s mismatch, expected %0d, got %0d",
							$time, chan_name[i], want[i], got[i]);
					end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset defaults: white, black, gray, primaries
		gap_pct = 0;
		add_pixel(CMD_RGB2CMYK, 16'd32768, 16'd32768, 16'd32768, 16'd0);
		add_pixel(CMD_RGB2CMYK, 16'd0, 16'd0, 16'd0, 16'd0);
		add_pixel(CMD_RGB2CMYK, 16'd16384, 16'd16384, 16'd16384, 16'd0);
		add_pixel(CMD_RGB2CMYK, 16'd32768, 16'd0, 16'd0, 16'd0);
		// black input is ignored going forward
		add_pixel(CMD_RGB2CMYK, 16'd0, 16'd32768, 16'd0, 16'hffff);
		add_pixel(CMD_RGB2CMYK, 16'd0, 16'd0, 16'd32768, 16'd12345);
		// channels above one saturate
		add_pixel(CMD_RGB2CMYK, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		add_pixel(CMD_RGB2CMYK, 16'd40000, 16'd0, 16'd50000, 16'd0);
		// offset larger than the darkest ink gives no black; the next pixel's darkest ink exceeds it
		add_pixel(CMD_RGB2CMYK, 16'd32768, 16'd26214, 16'd32768, 16'd0);
		add_pixel(CMD_RGB2CMYK, 16'd20000, 16'd10000, 16'd5000, 16'd0);
		// reverse direction
		add_pixel(CMD_CMYK2RGB, 16'd0, 16'd0, 16'd0, 16'd0);
		add_pixel(CMD_CMYK2RGB, 16'd32768, 16'd32768, 16'd32768, 16'd0);
		add_pixel(CMD_CMYK2RGB, 16'd0, 16'd0, 16'd0, 16'd32768);
		add_pixel(CMD_CMYK2RGB, 16'd16384, 16'd8192, 16'd0, 16'd16384);
		add_pixel(CMD_CMYK2RGB, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		add_pixel(CMD_CMYK2RGB, 16'd32768, 16'd0, 16'd16384, 16'd40000);
		add_pixel(CMD_CMYK2RGB, 16'd1, 16'd2, 16'd3, 16'd32767);
		add_pixel(CMD_CMYK2RGB, 16'd50000, 16'd32767, 16'd1, 16'd1);
		drain();

		// random, defaults, sender never idle
		add_random_pixels(110, 0);
		drain();

		// no offset, black allowed up to one minus an lsb
		write_reg(REG_BLACK_OFFSET, 16'd0);
		write_reg(REG_BLACK_MAX, 16'd32767);
		gap_pct = 0;
		add_pixel(CMD_RGB2CMYK, 16'd0, 16'd0, 16'd0, 16'd0);
		add_pixel(CMD_RGB2CMYK, 16'd1, 16'd1, 16'd1, 16'd0);
		add_pixel(CMD_RGB2CMYK, 16'd0, 16'd100, 16'd3, 16'd0);
		add_random_pixels(110, 45);
		drain();

		// offset of one and black pinned at zero
		write_reg(REG_BLACK_OFFSET, 16'd32768);
		write_reg(REG_BLACK_MAX, 16'd0);
		add_random_pixels(60, 31);
		drain();

		// offset beyond one, every bit of both registers set at some point
		write_reg(REG_BLACK_OFFSET, 16'hffff);
		write_reg(REG_BLACK_MAX, 16'd13107);
		add_random_pixels(60, 0);
		drain();

		// random settings
		write_reg(REG_BLACK_OFFSET, CFG_W'($urandom_range(32768)));
		write_reg(REG_BLACK_MAX, CFG_W'($urandom_range(32767)));
		add_random_pixels(110, 45);
		drain();

		write_reg(REG_BLACK_OFFSET, CFG_W'($urandom_range(8192)));
		write_reg(REG_BLACK_MAX, CFG_W'($urandom_range(32767, 16384)));
		add_random_pixels(100, 31);
		drain();

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
